@@ design/http_chunked_body_decoder_macros.svh @@
// -----------------------------------------------------------------------------
// http_chunked_body_decoder_macros
// Assertion macros for the chunked body decoder. The clock is "clock" and
// the synchronous reset is "reset" in every file that uses them.
// -----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HCBD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define HCBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/hcbd_pkg.sv @@
// -----------------------------------------------------------------------------
// hcbd_pkg
// Types, codes and character helpers for the chunked body decoder.
// -----------------------------------------------------------------------------
package hcbd_pkg;

   localparam int SIZE_BITS_DEF = 32;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   // result kind codes
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   typedef enum logic [1:0] {
      PH_SIZE = 2'd0,
      PH_DATA = 2'd1,
      PH_DONE = 2'd2,
      PH_ERR  = 2'd3
   } phase_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok  = 1'b1;
      h.val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.val = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.val = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.val = 4'(c - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   // space, TAB, LF, VT, FF, CR
   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

endpackage

@@ design/http_chunked_body_decoder.sv @@
// -----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP/1.1 chunked body one byte per transfer.
// -----------------------------------------------------------------------------
// Takes one body byte per cycle, back to back, and produces at most one result
// per byte: a payload byte, an end-of-message marker or a framing error. The
// whole per-byte parse (size line, chunk data count, trailing CR LF) is one
// short state update, so a byte is accepted every cycle; the result sits in
// an output register in the cycle after its byte, and the input stalls only
// while that register is full and the output side stalls. msg_start clears
// the decoder before the byte is used. After end of message or an error,
// bytes give no result until the next msg_start.

`include "http_chunked_body_decoder_macros.svh"

module http_chunked_body_decoder #(
   parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_msg_start,
   input  logic       req_msg_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind
);

   localparam logic [SIZE_BITS-1:0] SIZE_ONE = SIZE_BITS'(1);

   hcbd_pkg::phase_type   phase_ff, phase_in;
   logic [SIZE_BITS-1:0]  size_accum_ff, size_accum_in;
   logic [SIZE_BITS-1:0]  bytes_left_ff, bytes_left_in;
   logic                  digits_seen_ff, digits_seen_in;
   logic                  number_closed_ff, number_closed_in;
   logic                  line_has_text_ff, line_has_text_in;
   logic                  blank_used_ff, blank_used_in;
   logic                  cr_pending_ff, cr_pending_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_out_byte_ff, rsp_out_byte_in;
   logic [1:0]            rsp_kind_ff, rsp_kind_in;

   logic                  req_accept;
   logic                  emit;

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign req_accept   = req_valid && !req_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_kind     = rsp_kind_ff;

   always_comb begin
      hcbd_pkg::phase_type  ph;
      logic [SIZE_BITS-1:0] acc;
      logic [SIZE_BITS-1:0] left;
      logic                 ds, nc, lht, bu, crp, ok;
      logic [1:0]           kind;
      logic [7:0]           ob;
      hcbd_pkg::hex_type    hx;

      ph   = phase_ff;
      acc  = size_accum_ff;
      left = bytes_left_ff;
      ds   = digits_seen_ff;
      nc   = number_closed_ff;
      lht  = line_has_text_ff;
      bu   = blank_used_ff;
      crp  = cr_pending_ff;
      ok   = 1'b1;
      emit = 1'b0;
      kind = hcbd_pkg::KIND_DATA;
      ob   = 8'd0;
      hx   = hcbd_pkg::hex_decode(req_in_byte);

      if (req_msg_start) begin
         ph   = hcbd_pkg::PH_SIZE;
         acc  = '0;
         left = '0;
         ds   = 1'b0;
         nc   = 1'b0;
         lht  = 1'b0;
         bu   = 1'b0;
         crp  = 1'b0;
      end

      unique case (ph) inside
         hcbd_pkg::PH_DATA: begin
            emit = 1'b1;
            ob   = req_in_byte;
            left = left - SIZE_ONE;
            if (left == '0) begin
               ph  = hcbd_pkg::PH_SIZE;
               bu  = 1'b0;
               acc = '0;
               ds  = 1'b0;
               nc  = 1'b0;
               lht = 1'b0;
               crp = 1'b0;
            end
         end
         hcbd_pkg::PH_SIZE: begin
            if (crp && req_in_byte == hcbd_pkg::CHAR_LF) begin
               if (!lht && !bu) begin
                  // the one blank line allowed before a size line
                  bu = 1'b1;
               end else if (!ds || acc == '0) begin
                  ph   = hcbd_pkg::PH_DONE;
                  kind = hcbd_pkg::KIND_END;
                  emit = 1'b1;
               end else begin
                  ph   = hcbd_pkg::PH_DATA;
                  left = acc;
                  bu   = 1'b0;
               end
               acc = '0;
               ds  = 1'b0;
               nc  = 1'b0;
               lht = 1'b0;
               crp = 1'b0;
            end else begin
               // lone CR: an ordinary line character (white space before digits)
               if (crp) begin
                  crp = 1'b0;
                  lht = 1'b1;
                  if (ds) begin
                     nc = 1'b1;
                  end
               end
               if (req_in_byte == hcbd_pkg::CHAR_CR) begin
                  crp = 1'b1;
               end else begin
                  lht = 1'b1;
                  if (!nc) begin
                     if (hx.ok) begin
                        if (acc[SIZE_BITS-1 -: 4] != 4'd0) begin
                           ok = 1'b0;
                        end else begin
                           acc = {acc[SIZE_BITS-5:0], hx.val};
                           ds  = 1'b1;
                        end
                     end else if (ds || !hcbd_pkg::is_space(req_in_byte)) begin
                        nc = 1'b1;
                     end
                  end
               end
               if (!ok) begin
                  ph   = hcbd_pkg::PH_ERR;
                  kind = hcbd_pkg::KIND_ERR;
                  emit = 1'b1;
               end
            end
         end
         hcbd_pkg::PH_DONE, hcbd_pkg::PH_ERR: begin
         end
      endcase

      // message cut short
      if (req_msg_last && (ph == hcbd_pkg::PH_SIZE || ph == hcbd_pkg::PH_DATA)) begin
         ph   = hcbd_pkg::PH_ERR;
         kind = hcbd_pkg::KIND_ERR;
         ob   = 8'd0;
         emit = 1'b1;
      end

      phase_in         = ph;
      size_accum_in    = acc;
      bytes_left_in    = left;
      digits_seen_in   = ds;
      number_closed_in = nc;
      line_has_text_in = lht;
      blank_used_in    = bu;
      cr_pending_in    = crp;
      rsp_out_byte_in  = ob;
      rsp_kind_in      = kind;

      if (req_accept && emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= hcbd_pkg::PH_SIZE;
         size_accum_ff    <= '0;
         bytes_left_ff    <= '0;
         digits_seen_ff   <= 1'b0;
         number_closed_ff <= 1'b0;
         line_has_text_ff <= 1'b0;
         blank_used_ff    <= 1'b0;
         cr_pending_ff    <= 1'b0;
      end else if (req_accept) begin
         phase_ff         <= phase_in;
         size_accum_ff    <= size_accum_in;
         bytes_left_ff    <= bytes_left_in;
         digits_seen_ff   <= digits_seen_in;
         number_closed_ff <= number_closed_in;
         line_has_text_ff <= line_has_text_in;
         blank_used_ff    <= blank_used_in;
         cr_pending_ff    <= cr_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_out_byte_ff <= rsp_out_byte_in;
         rsp_kind_ff     <= rsp_kind_in;
      end
   end

   `HCBD_ASSERT_IMPL(a_data_count_nonzero, phase_ff == hcbd_pkg::PH_DATA, bytes_left_ff != '0, "data phase with no bytes left")
   `HCBD_ASSERT_IMPL(a_marker_byte_zero, rsp_valid_ff && rsp_kind_ff != hcbd_pkg::KIND_DATA, rsp_out_byte_ff == 8'd0, "non-data result carries a byte")
   `HCBD_ASSERT_NEXT(a_done_sticks, req_accept && !req_msg_start && phase_ff == hcbd_pkg::PH_DONE, phase_ff == hcbd_pkg::PH_DONE, "left end state without message start")
   `HCBD_ASSERT_IMPL(a_stall_only_when_full, req_stall, rsp_valid_ff, "input stalled with empty result register")

endmodule
